FILE: rtl/rmart_pkg.sv
// Package for the run moving-average range tracker: beat types, action codes,
// ring sizing and the controller/datapath command and status structs. No dependencies.
package rmart_pkg;

  localparam int RingDepth = 16;
  localparam int RingAw    = $clog2(RingDepth);
  localparam int FillW     = $clog2(RingDepth + 1);
  localparam int NumTrk    = 8;
  localparam int SumW      = 28;
  localparam int MagW      = SumW - 1;

  // reciprocal constants: floor(n / d) = (n * M) >> s for any n below 2^27
  localparam int RecipW = 28;
  localparam int ProdW  = MagW + RecipW;
  localparam logic [RecipW-1:0] Recip3 = 28'd178956971;  // (2^29 + 1) / 3
  localparam logic [RecipW-1:0] Recip5 = 28'd214748365;  // (2^30 + 1) / 5
  localparam logic [4:0] Sh3  = 5'd29;
  localparam logic [4:0] Sh5  = 5'd30;
  localparam logic [4:0] Sh12 = 5'd31;  // divide by 3, then by 4

  localparam logic [1:0] ActStart  = 2'd0;
  localparam logic [1:0] ActSample = 2'd1;
  localparam logic [1:0] ActFinish = 2'd2;

  localparam logic [3:0] Win3  = 4'd3;
  localparam logic [3:0] Win5  = 4'd5;
  localparam logic [3:0] Win12 = 4'd12;

  localparam logic [15:0] AdvMax = 16'hFFFF;
  localparam logic [2:0]  LastTrk = 3'd7;

  typedef struct packed {
    logic [1:0]         action;
    logic [31:0]        timestamp_ms;
    logic signed [23:0] weight;
    logic signed [23:0] distance;
    logic               sample_valid;
    logic               advisory_event;
    logic               stop_abnormal;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         tracker_index;
    logic               range_valid;
    logic signed [23:0] range_min;
    logic signed [23:0] range_max;
    logic [31:0]        test_id;
    logic [31:0]        sample_count;
    logic [31:0]        run_time_ms;
    logic [15:0]        adv_total;
    logic               run_aborted;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic               ok;
    logic signed [23:0] w;
    logic signed [23:0] d;
  } ring_entry_t;

  typedef struct packed {
    logic start;
    logic sample;
    logic finish;
    logic rd;
    logic acc;
    logic div_start;
    logic div_step;
    logic feed;
    logic emit_next;
  } cmd_t;

  typedef struct packed {
    logic active;
    logic win_hit;
    logic walk_end;
    logic div_done;
    logic emit_last;
  } status_t;

endpackage

FILE: rtl/rmart_ctrl.sv
// Controller for the range tracker: one-hot state machine that sequences
// the ring walk, the divider and the result beats. Uses rmart_pkg.
module rmart_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [1:0]         action_i,
  output logic               in_stall_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  input  rmart_pkg::status_t sts_i,
  output rmart_pkg::cmd_t    cmd_o
);
  import rmart_pkg::*;

  typedef enum logic [6:0] {
    StIdle = 7'b0000001,
    StRd   = 7'b0000010,
    StAcc  = 7'b0000100,
    StChk  = 7'b0001000,
    StDiv  = 7'b0010000,
    StFeed = 7'b0100000,
    StEmit = 7'b1000000
  } state_e;

  state_e state_q, state_d;
  logic   in_acc;

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = (state_q == StEmit);
  assign in_acc      = in_valid_i && (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_acc) begin
          unique case (action_i)
            ActStart: cmd_o.start = 1'b1;
            ActSample: begin
              if (sts_i.active) begin
                cmd_o.sample = 1'b1;
                state_d      = StRd;
              end
            end
            ActFinish: begin
              if (sts_i.active) begin
                cmd_o.finish = 1'b1;
                state_d      = StEmit;
              end
            end
            default: ;
          endcase
        end
      end
      StRd: begin
        cmd_o.rd = 1'b1;
        state_d  = StAcc;
      end
      StAcc: begin
        cmd_o.acc = 1'b1;
        state_d   = StChk;
      end
      StChk: begin
        if (sts_i.win_hit) begin
          cmd_o.div_start = 1'b1;
          state_d         = StDiv;
        end else if (sts_i.walk_end) begin
          state_d = StIdle;
        end else begin
          state_d = StRd;
        end
      end
      StDiv: begin
        if (sts_i.div_done) state_d = StFeed;
        else cmd_o.div_step = 1'b1;
      end
      StFeed: begin
        cmd_o.feed = 1'b1;
        state_d    = sts_i.walk_end ? StIdle : StRd;
      end
      StEmit: begin
        if (!out_stall_i) begin
          cmd_o.emit_next = 1'b1;
          if (sts_i.emit_last) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/rmart_dp.sv
// Datapath for the range tracker: run counters, sample ring, window sums,
// reciprocal-multiply divider and the eight min/max lanes. Uses rmart_pkg.
module rmart_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rmart_pkg::in_item_t  in_item_i,
  input  rmart_pkg::cmd_t      cmd_i,
  output rmart_pkg::status_t   sts_o,
  output rmart_pkg::out_item_t out_item_o
);
  import rmart_pkg::*;

  logic                     active_q;
  logic [31:0]              next_id_q, cur_id_q, start_q, samples_q, dur_q;
  logic [15:0]              adv_q;
  logic                     abort_q;
  logic [RingAw-1:0]        head_q;
  logic [FillW-1:0]         fill_q;
  ring_entry_t              ring_mem [RingDepth];
  ring_entry_t              rd_q;
  logic [3:0]               cnt_q;
  logic                     ok_q;
  logic signed [SumW-1:0]   sum_w_q, sum_d_q;
  logic [MagW-1:0]          mag_w_q, mag_d_q, quo_w_q, quo_d_q;
  logic                     quo_ok_q;
  logic                     neg_w_q, neg_d_q;
  logic [1:0]               pair_q;
  logic [2:0]               emit_q;
  logic [NumTrk-1:0]        seen_q;
  logic signed [23:0]       low_q  [NumTrk];
  logic signed [23:0]       high_q [NumTrk];

  logic [RingAw:0]          head_x, cnt_x, rd_x;
  logic [RingAw-1:0]        rd_addr;
  logic [NumTrk-1:0]        feed_en;
  logic signed [23:0]       feed_w, feed_d, q_w, q_d;
  logic signed [SumW-1:0]   abs_w, abs_d;
  logic [RecipW-1:0]        recip;
  logic [4:0]               prod_sh;
  logic [ProdW-1:0]         prod_w, prod_d;
  logic                     is_win;

  // newest-first ring address: head - 1 - cnt, modulo depth
  assign head_x  = {1'b0, head_q};
  assign cnt_x   = (RingAw + 1)'(cnt_q);
  assign rd_x    = (head_x > cnt_x) ? (head_x - 1'b1 - cnt_x)
                                    : (head_x + (RingAw + 1)'(RingDepth - 1) - cnt_x);
  assign rd_addr = rd_x[RingAw-1:0];

  assign is_win          = (cnt_q == Win3) || (cnt_q == Win5) || (cnt_q == Win12);
  assign sts_o.active    = active_q;
  assign sts_o.win_hit   = is_win && ok_q && (fill_q >= FillW'(cnt_q));
  assign sts_o.walk_end  = !ok_q || (cnt_q == Win12) || (FillW'(cnt_q) >= fill_q);
  assign sts_o.div_done  = quo_ok_q;
  assign sts_o.emit_last = (emit_q == LastTrk);

  // sign-magnitude divide: magnitude times reciprocal, sign put back after
  assign abs_w   = sum_w_q[SumW-1] ? -sum_w_q : sum_w_q;
  assign abs_d   = sum_d_q[SumW-1] ? -sum_d_q : sum_d_q;
  assign recip   = (pair_q == 2'd2) ? Recip5 : Recip3;
  assign prod_sh = (pair_q == 2'd1) ? Sh3 : ((pair_q == 2'd2) ? Sh5 : Sh12);
  assign prod_w  = ProdW'(mag_w_q) * ProdW'(recip);
  assign prod_d  = ProdW'(mag_d_q) * ProdW'(recip);
  assign q_w     = neg_w_q ? -quo_w_q[23:0] : quo_w_q[23:0];
  assign q_d     = neg_d_q ? -quo_d_q[23:0] : quo_d_q[23:0];

  assign feed_w = cmd_i.sample ? in_item_i.weight : q_w;
  assign feed_d = cmd_i.sample ? in_item_i.distance : q_d;

  always_comb begin
    for (int t = 0; t < NumTrk; t++) begin
      if (t < 2) feed_en[t] = cmd_i.sample && in_item_i.sample_valid;
      else       feed_en[t] = cmd_i.feed && (pair_q == 2'(t / 2));
    end
  end

  // control and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      next_id_q <= '0;
      cur_id_q  <= '0;
      start_q   <= '0;
      samples_q <= '0;
      adv_q     <= '0;
      head_q    <= '0;
      fill_q    <= '0;
      seen_q    <= '0;
      emit_q    <= '0;
    end else begin
      if (cmd_i.start) begin
        active_q  <= 1'b1;
        cur_id_q  <= next_id_q;
        next_id_q <= next_id_q + 32'd1;
        start_q   <= in_item_i.timestamp_ms;
        samples_q <= '0;
        adv_q     <= '0;
        head_q    <= '0;
        fill_q    <= '0;
        seen_q    <= '0;
      end else begin
        if (cmd_i.sample) begin
          if (samples_q != '1) samples_q <= samples_q + 32'd1;
          if (in_item_i.advisory_event && adv_q != AdvMax) adv_q <= adv_q + 16'd1;
          head_q <= (head_q == RingAw'(RingDepth - 1)) ? '0 : head_q + 1'b1;
          if (fill_q != FillW'(RingDepth)) fill_q <= fill_q + 1'b1;
        end
        for (int t = 0; t < NumTrk; t++) begin
          if (feed_en[t]) seen_q[t] <= 1'b1;
        end
      end
      if (cmd_i.finish) emit_q <= '0;
      if (cmd_i.emit_next) begin
        if (emit_q == LastTrk) active_q <= 1'b0;
        else emit_q <= emit_q + 3'd1;
      end
    end
  end

  // ring memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.sample) begin
      ring_mem[head_q] <= '{ok: in_item_i.sample_valid, w: in_item_i.weight,
                            d: in_item_i.distance};
    end
    if (cmd_i.rd) rd_q <= ring_mem[rd_addr];
  end

  // window walk, divider and lanes
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      dur_q   <= (in_item_i.timestamp_ms >= start_q) ? in_item_i.timestamp_ms - start_q : '0;
      abort_q <= in_item_i.stop_abnormal;
    end
    if (cmd_i.sample) begin
      cnt_q   <= '0;
      ok_q    <= 1'b1;
      sum_w_q <= '0;
      sum_d_q <= '0;
    end else if (cmd_i.acc) begin
      cnt_q   <= cnt_q + 4'd1;
      ok_q    <= ok_q && rd_q.ok;
      sum_w_q <= sum_w_q + SumW'(rd_q.w);
      sum_d_q <= sum_d_q + SumW'(rd_q.d);
    end
    if (cmd_i.div_start) begin
      mag_w_q  <= abs_w[MagW-1:0];
      mag_d_q  <= abs_d[MagW-1:0];
      neg_w_q  <= sum_w_q[SumW-1];
      neg_d_q  <= sum_d_q[SumW-1];
      quo_ok_q <= 1'b0;
      pair_q   <= (cnt_q == Win3) ? 2'd1 : ((cnt_q == Win5) ? 2'd2 : 2'd3);
    end else if (cmd_i.div_step) begin
      quo_w_q  <= MagW'(prod_w >> prod_sh);
      quo_d_q  <= MagW'(prod_d >> prod_sh);
      quo_ok_q <= 1'b1;
    end
    for (int t = 0; t < NumTrk; t++) begin
      if (feed_en[t] && !cmd_i.start) begin
        if (!seen_q[t] || ((t % 2 == 1) ? feed_d : feed_w) < low_q[t])
          low_q[t] <= (t % 2 == 1) ? feed_d : feed_w;
        if (!seen_q[t] || ((t % 2 == 1) ? feed_d : feed_w) > high_q[t])
          high_q[t] <= (t % 2 == 1) ? feed_d : feed_w;
      end
    end
  end

  always_comb begin
    out_item_o.tracker_index = emit_q;
    out_item_o.range_valid   = seen_q[emit_q];
    out_item_o.range_min     = seen_q[emit_q] ? low_q[emit_q] : '0;
    out_item_o.range_max     = seen_q[emit_q] ? high_q[emit_q] : '0;
    out_item_o.test_id       = cur_id_q;
    out_item_o.sample_count  = samples_q;
    out_item_o.run_time_ms   = dur_q;
    out_item_o.adv_total     = adv_q;
    out_item_o.run_aborted   = abort_q;
    out_item_o.last          = (emit_q == LastTrk);
  end

endmodule

FILE: rtl/run_moving_average_range_tracker.sv
// Top level of the run moving-average range tracker: controller plus datapath.
// Depends on rmart_pkg, rmart_ctrl and rmart_dp.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid_i/in_stall_o | in_item_i  (rmart_pkg::in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_item_o (rmart_pkg::out_item_t)
//
// Start and ignored beats are taken in the idle state. A sample walks the ring
// newest first, up to 12 entries, each through read, accumulate and check, and
// each filled window adds a reciprocal multiply, quotient register and lane update.
// Finish leads to 8 output beats, each held while out_stall_i is high.
// Reset clears run state, id counter and tracker-seen bits; no clearing pass.
// in_stall_o stays high while a sample walk or the result beats are running.
module run_moving_average_range_tracker (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  rmart_pkg::in_item_t  in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rmart_pkg::out_item_t out_item_o
);
  import rmart_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // sequencer
  rmart_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .action_i    (in_item_i.action),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // storage and arithmetic
  rmart_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_item_o (out_item_o)
  );

  // no input is taken while result beats are pending
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input not stalled during result beats");

  // the last beat ends the burst
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_item_o.last) |=> !out_valid_o)
    else $error("result beat after last");

  // beats after a non-last one continue with the next tracker
  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && !out_item_o.last) |=>
    (out_valid_o && out_item_o.tracker_index == $past(out_item_o.tracker_index) + 3'd1))
    else $error("tracker index out of order");

endmodule
